@@ sv/population_variance_unit_core_macros.svh @@
// Assertion macros shared by the population variance unit checkers.
// Included by the checker file; needs no other file.
`ifndef POPULATION_VARIANCE_UNIT_CORE_MACROS_SVH
`define POPULATION_VARIANCE_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PVU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PVU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pvu_pkg.sv @@
// Package for the population variance unit: fixed result field widths and
// arithmetic constants. Depends on nothing.
`timescale 1ns / 1ps

package pvu_pkg;

  localparam int VAR_W     = 41;
  localparam int MEAN_W    = 16;
  localparam int COUNT_W   = 9;
  localparam int FRAC_BITS = 8;
  // The sum-of-squares accumulator width is capped at a 64-bit word.
  localparam int SQ_CAP_W  = 64;

endpackage

@@ sv/pvu_if.sv @@
// Channel interfaces of the population variance unit: sample input, result
// output and the internal job channel. Depends on pvu_pkg.
`timescale 1ns / 1ps

interface pvu_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink (input valid, input sample, input is_last, output ready);
endinterface

interface pvu_out_if ();
  logic                               valid;
  logic                               ready;
  logic [pvu_pkg::VAR_W-1:0]          variance_fixed;
  logic signed [pvu_pkg::MEAN_W-1:0]  mean_value;
  logic [pvu_pkg::COUNT_W-1:0]        sample_count;
  logic                               overflow;

  modport source (output valid, output variance_fixed, output mean_value,
                  output sample_count, output overflow, input ready);
  modport sink (input valid, input variance_fixed, input mean_value,
                input sample_count, input overflow, output ready);
endinterface

interface pvu_job_if #(
  parameter int WIDTH = 8
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/pvu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pvu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ sv/pvu_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; shared by the mean and the variance divisions.
`timescale 1ns / 1ps

module pvu_div #(
  parameter int DVD_W = 49,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/pvu_fifo.sv @@
// Short job queue between the front and back of the variance unit.
// Depends on pvu_job_if.
`timescale 1ns / 1ps

module pvu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  pvu_job_if.sink   wr_s,
  pvu_job_if.source rd_s
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [FW-1:0]    fill_r;
  logic             push;
  logic             pop;

  assign wr_s.ready = (fill_r != FW'(DEPTH));
  assign rd_s.valid = (fill_r != '0);
  assign rd_s.data  = mem_r[rd_ptr_r];
  assign push       = wr_s.valid && wr_s.ready;
  assign pop        = rd_s.valid && rd_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + FW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_s.data;
    end
  end

endmodule

@@ sv/pvu_front.sv @@
// Front of the variance unit: takes sample requests, writes the sample store,
// keeps count, sum and drop flag, and posts one job per closed set.
// Depends on pvu_in_if and pvu_job_if.
`timescale 1ns / 1ps

module pvu_front #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pvu_in_if.sink                           in_s,
  pvu_job_if.source                        job_s,
  input  logic                             store_busy,
  output logic                             ram_we,
  output logic [$clog2(MAX_SAMPLES)-1:0]   ram_waddr,
  output logic [SAMPLE_BITS-1:0]           ram_wdata
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int JOB_W = 1 + SUM_W + CNT_W;

  logic [CNT_W-1:0] count_r;
  logic [SUM_W-1:0] sum_r;
  logic             drop_r;
  logic             job_valid_r;
  logic [JOB_W-1:0] job_data_r;

  logic             accept;
  logic             full;
  logic             store;
  logic [CNT_W-1:0] count_nxt;
  logic [SUM_W-1:0] sum_nxt;
  logic             drop_nxt;

  // The store is shared with the back's second pass, so intake waits for it.
  assign in_s.ready = !job_valid_r && !store_busy;
  assign accept     = in_s.valid && in_s.ready;
  assign full       = (count_r == CNT_W'(MAX_SAMPLES));
  assign store      = accept && !full;

  always_comb begin
    count_nxt = store ? count_r + CNT_W'(1) : count_r;
    sum_nxt   = store ? sum_r + {{CNT_W{in_s.sample[SAMPLE_BITS-1]}}, in_s.sample} : sum_r;
    drop_nxt  = drop_r || (accept && full);
  end

  assign ram_we    = store;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = in_s.sample;

  assign job_s.valid = job_valid_r;
  assign job_s.data  = job_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      if (job_s.valid && job_s.ready) begin
        job_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_s.is_last) begin
          count_r     <= '0;
          sum_r       <= '0;
          drop_r      <= 1'b0;
          job_valid_r <= 1'b1;
        end else begin
          count_r <= count_nxt;
          sum_r   <= sum_nxt;
          drop_r  <= drop_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_s.is_last) begin
      job_data_r <= {drop_nxt, sum_nxt, count_nxt};
    end
  end

endmodule

@@ sv/pvu_back.sv @@
// Back of the variance unit: per job, divides for the mean, runs the
// squared-deviation pass over the store, divides for the variance and emits.
// Depends on pvu_pkg, pvu_job_if and pvu_out_if.
`timescale 1ns / 1ps

module pvu_back #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pvu_job_if.sink                        job_s,
  pvu_out_if.source                      out_s,
  output logic                           store_busy,
  output logic [$clog2(MAX_SAMPLES)-1:0] ram_raddr,
  input  logic [SAMPLE_BITS-1:0]         ram_rdata,
  output logic                           div_start,
  output logic [((2*SAMPLE_BITS+$clog2(MAX_SAMPLES+1)) > pvu_pkg::SQ_CAP_W ?
                 pvu_pkg::SQ_CAP_W : (2*SAMPLE_BITS+$clog2(MAX_SAMPLES+1)))
                + pvu_pkg::FRAC_BITS - 1:0] div_dividend,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] div_divisor,
  input  logic                           div_done,
  input  logic [((2*SAMPLE_BITS+$clog2(MAX_SAMPLES+1)) > pvu_pkg::SQ_CAP_W ?
                 pvu_pkg::SQ_CAP_W : (2*SAMPLE_BITS+$clog2(MAX_SAMPLES+1)))
                + pvu_pkg::FRAC_BITS - 1:0] div_quotient
);

  localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int AW        = $clog2(MAX_SAMPLES);
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int JOB_W     = 1 + SUM_W + CNT_W;
  localparam int SQP_W     = 2 * SAMPLE_BITS;
  localparam int SQ_RAW    = SQP_W + CNT_W;
  localparam int SQ_W      = (SQ_RAW > pvu_pkg::SQ_CAP_W) ? pvu_pkg::SQ_CAP_W : SQ_RAW;
  localparam int FRAC_BITS = pvu_pkg::FRAC_BITS;
  localparam int DVD_W     = SQ_W + FRAC_BITS;
  localparam int VAR_W     = pvu_pkg::VAR_W;
  localparam int MEAN_W    = pvu_pkg::MEAN_W;
  localparam int COUNT_W   = pvu_pkg::COUNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MEAN = 3'd1;
  localparam logic [2:0] ST_PASS = 3'd2;
  localparam logic [2:0] ST_VAR  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                    state_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [CNT_W-1:0]              rd_idx_r;
  logic                          neg_r;
  logic                          drop_r;
  logic signed [SAMPLE_BITS-1:0] mean_r;
  logic                          rd_v_r;
  logic                          abs_v_r;
  logic                          sq_v_r;
  logic [SAMPLE_BITS-1:0]        abs_r;
  logic [SQP_W-1:0]              sq_r;
  logic [SQ_W-1:0]               acc_r;
  logic                          out_valid_r;
  logic [VAR_W-1:0]              out_var_r;
  logic signed [MEAN_W-1:0]      out_mean_r;
  logic [COUNT_W-1:0]            out_cnt_r;
  logic                          out_ovf_r;

  logic [CNT_W-1:0]              job_cnt;
  logic [SUM_W-1:0]              job_sum;
  logic                          job_drop;
  logic [SUM_W-1:0]              sum_mag;
  logic [SAMPLE_BITS-1:0]        q_lo;
  logic [SAMPLE_BITS-1:0]        mean_nxt;
  logic [SAMPLE_BITS:0]          dev;
  logic [SAMPLE_BITS:0]          dev_mag;
  logic                          issuing;
  logic                          pass_done;
  logic                          emit_load;

  always_comb begin
    job_cnt  = job_s.data[CNT_W-1:0];
    job_sum  = job_s.data[CNT_W +: SUM_W];
    job_drop = job_s.data[JOB_W-1];
    sum_mag  = job_sum[SUM_W-1] ? (~job_sum + SUM_W'(1)) : job_sum;
    // The quotient magnitude never exceeds half the sample range.
    q_lo     = div_quotient[SAMPLE_BITS-1:0];
    mean_nxt = neg_r ? (~q_lo + SAMPLE_BITS'(1)) : q_lo;
    dev      = {ram_rdata[SAMPLE_BITS-1], ram_rdata} - {mean_r[SAMPLE_BITS-1], mean_r};
    dev_mag  = dev[SAMPLE_BITS] ? (~dev + (SAMPLE_BITS+1)'(1)) : dev;
  end

  assign issuing   = (state_r == ST_PASS) && (rd_idx_r != cnt_r);
  assign pass_done = (state_r == ST_PASS) && (rd_idx_r == cnt_r) &&
                     !rd_v_r && !abs_v_r && !sq_v_r;
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_s.ready);

  assign job_s.ready = (state_r == ST_IDLE);
  assign store_busy  = job_s.valid || (state_r == ST_MEAN) || (state_r == ST_PASS);
  assign ram_raddr   = rd_idx_r[AW-1:0];

  assign div_start    = ((state_r == ST_IDLE) && job_s.valid) || pass_done;
  assign div_dividend = (state_r == ST_IDLE) ? DVD_W'(sum_mag)
                                             : {acc_r, {FRAC_BITS{1'b0}}};
  assign div_divisor  = (state_r == ST_IDLE) ? job_cnt : cnt_r;

  assign out_s.valid          = out_valid_r;
  assign out_s.variance_fixed = out_var_r;
  assign out_s.mean_value     = out_mean_r;
  assign out_s.sample_count   = out_cnt_r;
  assign out_s.overflow       = out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      abs_v_r     <= 1'b0;
      sq_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r  <= issuing;
      abs_v_r <= rd_v_r;
      sq_v_r  <= abs_v_r;
      case (state_r)
        ST_IDLE: begin
          if (job_s.valid) begin
            state_r <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            state_r <= ST_PASS;
          end
        end
        ST_PASS: begin
          if (pass_done) begin
            state_r <= ST_VAR;
          end
        end
        ST_VAR: begin
          if (div_done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && job_s.valid) begin
      cnt_r  <= job_cnt;
      neg_r  <= job_sum[SUM_W-1];
      drop_r <= job_drop;
    end
    if ((state_r == ST_MEAN) && div_done) begin
      mean_r   <= mean_nxt;
      rd_idx_r <= '0;
      acc_r    <= '0;
    end
    if (issuing) begin
      rd_idx_r <= rd_idx_r + CNT_W'(1);
    end
    // Read data, absolute deviation, square and accumulate are one stage each.
    abs_r <= dev_mag[SAMPLE_BITS-1:0];
    sq_r  <= SQP_W'(abs_r) * SQP_W'(abs_r);
    if (sq_v_r) begin
      acc_r <= acc_r + SQ_W'(sq_r);
    end
    if (emit_load) begin
      out_var_r  <= VAR_W'(div_quotient);
      out_mean_r <= MEAN_W'(mean_r);
      out_cnt_r  <= COUNT_W'(cnt_r);
      out_ovf_r  <= drop_r;
    end
  end

endmodule

@@ sv/population_variance_unit_core.sv @@
// Population variance unit top level: front, job queue, back, sample store, divider.
// The divider is bit-serial over a D-bit dividend, where
// D = min(2*SAMPLE_BITS + clog2(MAX_SAMPLES+1), 64) + 8 (D = 49 by default).
// Throughput: one sample per cycle while intake is not held; the next set starts after the
// store pass.
// Reset (synchronous, rst_n low) empties the set, the queue and the result register.
`timescale 1ns / 1ps

module population_variance_unit_core #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pvu_in_if.sink    in_s,
  pvu_out_if.source out_s
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int JOB_W  = 1 + SUM_W + CNT_W;
  localparam int SQ_RAW = 2 * SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = (SQ_RAW > pvu_pkg::SQ_CAP_W) ? pvu_pkg::SQ_CAP_W : SQ_RAW;
  localparam int DVD_W  = SQ_W + pvu_pkg::FRAC_BITS;

  pvu_job_if #(.WIDTH(JOB_W)) front_job ();
  pvu_job_if #(.WIDTH(JOB_W)) back_job ();

  logic                   store_busy;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   div_start;
  logic [DVD_W-1:0]       div_dividend;
  logic [CNT_W-1:0]       div_divisor;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quotient;

  pvu_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .job_s      (front_job),
    .store_busy (store_busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  pvu_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_s  (front_job),
    .rd_s  (back_job)
  );

  pvu_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pvu_div #(
    .DVD_W(DVD_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  pvu_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_s        (back_job),
    .out_s        (out_s),
    .store_busy   (store_busy),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient)
  );

endmodule

@@ sv/pvu_checker.sv @@
// Port-level checker for the population variance unit, bound to the top level.
// Depends on pvu_pkg and population_variance_unit_core_macros.svh.
`timescale 1ns / 1ps
`include "population_variance_unit_core_macros.svh"

module pvu_checker #(
  parameter int MAX_SAMPLES = 256
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_is_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pvu_pkg::VAR_W-1:0]         out_variance_fixed,
  input logic [pvu_pkg::MEAN_W-1:0]        out_mean_value,
  input logic [pvu_pkg::COUNT_W-1:0]       out_sample_count,
  input logic                              out_overflow
);

  localparam int COUNT_W = pvu_pkg::COUNT_W;
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_SAMPLES);

  `PVU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                   "result dropped while stalled")
  `PVU_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                   $stable(out_variance_fixed) && $stable(out_mean_value) &&
                   $stable(out_sample_count) && $stable(out_overflow),
                   "result changed while stalled")
  // Closing a set hands the store to the second pass, so intake pauses.
  `PVU_ASSERT_NEXT(a_last_blocks, clk, rst_n, in_valid && in_ready && in_is_last,
                   !in_ready, "sample taken right after set close")
  // Samples are dropped only once the store is full.
  `PVU_ASSERT_IMPLIES(a_ovf_full, clk, rst_n, out_valid && out_overflow,
                      out_sample_count == FULL_COUNT, "overflow with store not full")

endmodule

bind population_variance_unit_core pvu_checker #(
  .MAX_SAMPLES(MAX_SAMPLES)
) u_pvu_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_s.valid),
  .in_ready           (in_s.ready),
  .in_is_last         (in_s.is_last),
  .out_valid          (out_s.valid),
  .out_ready          (out_s.ready),
  .out_variance_fixed (out_s.variance_fixed),
  .out_mean_value     (out_s.mean_value),
  .out_sample_count   (out_s.sample_count),
  .out_overflow       (out_s.overflow)
);

@@ dv/tb_top.sv @@
// Testbench for population_variance_unit_core: sends sample sets, predicts mean, variance,
// count and drop flag per set, and checks each result request. Depends on pvu_pkg and pvu_if.sv.
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_DEPTH = 256;
  localparam int SAMPLE_W    = 16;
  localparam int TARGET_SAMPLES = 1950;
  localparam int SAMPLE_MAX  = 32767;
  localparam int SAMPLE_MIN  = -32768;

  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT, SPREAD_EXTREME} spread_t;

  typedef struct {
    logic [pvu_pkg::VAR_W-1:0]         variance;
    logic signed [pvu_pkg::MEAN_W-1:0] mean;
    logic [pvu_pkg::COUNT_W-1:0]       count;
    logic                              dropped;
  } set_stats_t;

  logic clk;
  logic rst_n;

  pvu_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  pvu_out_if out_if ();

  population_variance_unit_core #(
    .MAX_SAMPLES(STORE_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_if),
    .out_s(out_if)
  );

  always #5 clk = ~clk;

  // Shadow of the set being collected by the block.
  logic signed [SAMPLE_W-1:0] held_samples [STORE_DEPTH];
  int unsigned held_count;
  longint      held_sum;
  bit          held_dropped;

  set_stats_t pending_stats[$];

  int  error_count;
  int  samples_sent;
  int  sets_closed;
  int  sets_with_drops;
  int  results_checked;
  bit  gaps_on;
  int  rx_hold;
  int  rx_wait;

  function automatic void fold_sample(logic signed [SAMPLE_W-1:0] value, bit last);
    set_stats_t        r;
    longint            mean_l;
    longint            d;
    longint unsigned   n;
    longint unsigned   sq;
    longint unsigned   v;
    if (held_count < STORE_DEPTH) begin
      held_samples[held_count] = value;
      held_count++;
      held_sum += value;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;
    n      = held_count;
    sq     = 0;
    mean_l = 0;
    v      = 0;
    if (n != 0) begin
      // Signed division truncates toward zero, as the block does.
      mean_l = held_sum / longint'(n);
      for (int i = 0; i < held_count; i++) begin
        d = longint'(held_samples[i]) - mean_l;
        sq += longint'(d * d);
      end
      v = (sq / n) * (1 << pvu_pkg::FRAC_BITS) + ((sq % n) * (1 << pvu_pkg::FRAC_BITS)) / n;
    end
    r.variance = v[pvu_pkg::VAR_W-1:0];
    r.mean     = mean_l[pvu_pkg::MEAN_W-1:0];
    r.count    = n[pvu_pkg::COUNT_W-1:0];
    r.dropped  = held_dropped;
    pending_stats.push_back(r);
    sets_closed++;
    if (held_dropped) sets_with_drops++;
    held_count   = 0;
    held_sum     = 0;
    held_dropped = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic check_result();
    set_stats_t want;
    if (pending_stats.size() == 0) begin
      report_mismatch("result with no set pending, count", out_if.sample_count, 0);
      return;
    end
    want = pending_stats.pop_front();
    results_checked++;
    if (out_if.variance_fixed !== want.variance)
      report_mismatch("variance_fixed", out_if.variance_fixed, want.variance);
    if (out_if.mean_value !== want.mean)
      report_mismatch("mean_value", out_if.mean_value, want.mean);
    if (out_if.sample_count !== want.count)
      report_mismatch("sample_count", out_if.sample_count, want.count);
    if (out_if.overflow !== want.dropped)
      report_mismatch("overflow", out_if.overflow, want.dropped);
  endtask

  // Result side: checks each accepted request, then idles for a random number of
  // cycles or for a long hold when one is requested.
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      check_result();
      rx_wait = gaps_on ? $urandom_range(0, 4) : 0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_if.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input bit last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= value;
    in_if.is_last <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    fold_sample(value, last);
    samples_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(spread_t kind, int center);
    int v;
    case (kind)
      SPREAD_NARROW: begin
        v = center + $urandom_range(0, 16) - 8;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      end
      SPREAD_FLAT:    v = center;
      SPREAD_EXTREME: v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default:        v = $urandom_range(0, 65535) - 32768;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_set(input int size, input spread_t kind);
    int center;
    center = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < size; i++) begin
      send_sample(pick_sample(kind, center), i == size - 1);
    end
  endtask

  task automatic test_single_extremes();
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sh5556, 1'b1);
  endtask

  task automatic test_wide_spread();
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b1);
  endtask

  task automatic test_mean_truncation();
    // Negative sums must round toward zero, not toward minus infinity.
    send_sample(-16'sd3, 1'b0);
    send_sample(-16'sd4, 1'b1);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd4, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd2, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
  endtask

  task automatic test_store_full();
    // Exactly a full store, then a set whose tail, last sample included, is dropped.
    send_set(STORE_DEPTH, SPREAD_FULL);
    for (int i = 0; i < STORE_DEPTH + 3; i++) begin
      send_sample(pick_sample(SPREAD_FULL, 0), i == STORE_DEPTH + 2);
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_hold = 500;
    for (int s = 0; s < 8; s++) send_set(10, SPREAD_FULL);
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_sets();
    int      size;
    spread_t kind;
    while (samples_sent < TARGET_SAMPLES) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 24) == 0) size = $urandom_range(STORE_DEPTH - 16, STORE_DEPTH + 14);
      else                            size = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0:       kind = SPREAD_FLAT;
        1:       kind = SPREAD_EXTREME;
        2, 3:    kind = SPREAD_NARROW;
        default: kind = SPREAD_FULL;
      endcase
      send_set(size, kind);
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    in_if.valid <= 1'b0;
    gaps_on = 1'b1;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    in_if.is_last = 1'b0;
    out_if.ready  = 1'b0;
    held_count    = 0;
    held_sum      = 0;
    held_dropped  = 1'b0;
    error_count   = 0;
    samples_sent  = 0;
    sets_closed   = 0;
    sets_with_drops = 0;
    results_checked = 0;
    rx_hold       = 0;
    rx_wait       = 0;
    gaps_on       = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_extremes();
    test_wide_spread();
    test_mean_truncation();
    drain_results();
    test_store_full();
    test_backpressure();
    test_random_sets();

    drain_results();
    // Any result that shows up now has no set behind it.
    repeat (500) @(posedge clk);
    $display("Run covered %0d samples in %0d sets (%0d with dropped samples);",
             samples_sent, sets_closed, sets_with_drops);
    $display("%0d results checked, %0d mismatches.", results_checked, error_count);
    if (error_count == 0 && pending_stats.size() == 0) begin
      $display("** population_variance_unit_core: PASSED **");
    end else begin
      $display("** population_variance_unit_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", pending_stats.size());
    $display("** population_variance_unit_core: FAILED **");
    $finish;
  end

endmodule
